// ===== sv/dual_sensor_train_tracker_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef DUAL_SENSOR_TRAIN_TRACKER_DEFINES_SVH
`define DUAL_SENSOR_TRAIN_TRACKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dst_pkg.sv =====
`default_nettype none

package dst_pkg;

	localparam int SENS_W  = 4;
	localparam int TIME_W  = 63;
	localparam int SPEED_W = 24;
	localparam int SEC_W   = 2;
	localparam int CNT_W   = 8;
	localparam int NUM_W   = 64;

	localparam logic [CNT_W-1:0]   CLEAR_LIMIT_RST = 8'd10;
	localparam logic [NUM_W-1:0]   NUM_ROUND       = 64'd32169984000000;
	localparam logic [NUM_W-1:0]   NUM_STRAIGHT    = 64'd23040000000000;
	localparam logic [SPEED_W-1:0] SPEED_MAX       = '1;
	localparam logic [7:0]         ROUND_SECTOR_A  = 8'd0;
	localparam logic [7:0]         ROUND_SECTOR_B  = 8'd2;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_STEAM = 2'd1,
		MODE_CHECK = 2'd2
	} mode_t;

	typedef struct packed {
		logic [TIME_W-1:0] prev;
		logic [TIME_W-1:0] cur;
	} pair_t;

	typedef struct packed {
		logic  start;
		logic  round;
		pair_t times;
	} div_req_t;

endpackage

`default_nettype wire

// ===== sv/dst_in_if.sv =====
`default_nettype none

interface dst_in_if;
	import dst_pkg::*;

	logic              valid;
	logic              ready;
	logic [SENS_W-1:0] top_sensors;
	logic [SENS_W-1:0] bottom_sensors;
	logic [TIME_W-1:0] time_ns;

	modport source (output valid, top_sensors, bottom_sensors, time_ns, input ready);
	modport sink (input valid, top_sensors, bottom_sensors, time_ns, output ready);
endinterface

`default_nettype wire

// ===== sv/dst_out_if.sv =====
`default_nettype none

interface dst_out_if;
	import dst_pkg::*;

	logic               valid;
	logic               ready;
	logic [SEC_W-1:0]   diesel_sector;
	logic [SEC_W-1:0]   steam_sector;
	logic [SPEED_W-1:0] diesel_speed;
	logic [SPEED_W-1:0] steam_speed;

	modport source (output valid, diesel_sector, steam_sector, diesel_speed, steam_speed,
		input ready);
	modport sink (input valid, diesel_sector, steam_sector, diesel_speed, steam_speed,
		output ready);
endinterface

`default_nettype wire

// ===== sv/dual_sensor_train_tracker.sv =====
// Train tracker for a looped track with up to four sectors.
// The sample channel carries one word per sensor poll: the upper and lower
// sensor bits of every sector and the poll time in nanoseconds. The result
// channel returns one word per sample with the sector each train last left
// and both speeds in unsigned Q16.8 cm/s, saturated, zero when not known.
// Both channels move a word when valid and ready are high at a clock edge.
// The clear limit register is written through cfg_wen and cfg_wdata.
// A sample walks the sectors, one per cycle, and then has two speed
// calculations on one shared restoring divider. Each one gives zero or
// the saturated speed straight from its check state, or else divides, one
// quotient bit per cycle; the second starts in the done state of the first.
// A new sample is taken once the previous one has reached the output register,
// even if that result is still waiting; a stalled receiver holds the block
// only when a second result is ready to replace the one it has not taken.
// Reset clears all sectors to idle, both trains to sector 0 with no time,
// the clear counters to zero and the clear limit to 10.
`default_nettype none

module dual_sensor_train_tracker #(
	parameter int NUM_SECTORS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dst_in_if.sink                      sample,
	dst_out_if.source                   result,
	input  logic                        cfg_wen,
	input  logic [dst_pkg::CNT_W-1:0]   cfg_wdata
);
	import dst_pkg::*;

	localparam int SW = $clog2(NUM_SECTORS);

	typedef enum logic [4:0] {
		T_IDLE   = 5'b00001,
		T_SCAN   = 5'b00010,
		T_DIESEL = 5'b00100,
		T_STEAM  = 5'b01000,
		T_OUT    = 5'b10000
	} tstate_t;

	tstate_t            state_q;
	logic [CNT_W-1:0]   clear_limit_q;
	logic               out_valid_q;
	logic [SEC_W-1:0]   out_dsec_q;
	logic [SEC_W-1:0]   out_ssec_q;
	logic [SPEED_W-1:0] out_dspd_q;
	logic [SPEED_W-1:0] out_sspd_q;
	logic [SPEED_W-1:0] diesel_speed_q;
	logic [SPEED_W-1:0] steam_speed_q;

	logic               scan_start;
	logic               scan_done;
	pair_t              steam_times;
	pair_t              diesel_times;
	logic [SW-1:0]      steam_sector;
	logic [SW-1:0]      diesel_sector;
	logic [SW-1:0]      sel_sector;
	logic [7:0]         sel_sector8;
	div_req_t           div_req;
	logic               div_done;
	logic [SPEED_W-1:0] div_quot;
	logic               out_load;

	assign sample.ready = (state_q == T_IDLE);
	assign scan_start   = sample.valid && sample.ready;
	assign out_load     = (state_q == T_OUT) && (!out_valid_q || result.ready);

	dst_scan #(
		.NUM_SECTORS(NUM_SECTORS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (scan_start),
		.top_sensors   (sample.top_sensors),
		.bottom_sensors(sample.bottom_sensors),
		.time_ns       (sample.time_ns),
		.clear_limit   (clear_limit_q),
		.done          (scan_done),
		.steam_times   (steam_times),
		.diesel_times  (diesel_times),
		.steam_sector  (steam_sector),
		.diesel_sector (diesel_sector)
	);

	always_comb begin
		sel_sector    = (state_q == T_SCAN) ? diesel_sector : steam_sector;
		sel_sector8   = 8'(sel_sector);
		div_req.start = ((state_q == T_SCAN) && scan_done) ||
			((state_q == T_DIESEL) && div_done);
		div_req.round = (sel_sector8 == ROUND_SECTOR_A) || (sel_sector8 == ROUND_SECTOR_B);
		div_req.times = (state_q == T_SCAN) ? diesel_times : steam_times;
	end

	dst_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			clear_limit_q <= CLEAR_LIMIT_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				clear_limit_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (scan_start) begin
						state_q <= T_SCAN;
					end
				end
				T_SCAN: begin
					if (scan_done) begin
						state_q <= T_DIESEL;
					end
				end
				T_DIESEL: begin
					if (div_done) begin
						state_q <= T_STEAM;
					end
				end
				T_STEAM: begin
					if (div_done) begin
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_load) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == T_DIESEL) && div_done) begin
			diesel_speed_q <= div_quot;
		end
		if ((state_q == T_STEAM) && div_done) begin
			steam_speed_q <= div_quot;
		end
		if (out_load) begin
			out_dsec_q <= SEC_W'(diesel_sector);
			out_ssec_q <= SEC_W'(steam_sector);
			out_dspd_q <= diesel_speed_q;
			out_sspd_q <= steam_speed_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.diesel_sector = out_dsec_q;
	assign result.steam_sector  = out_ssec_q;
	assign result.diesel_speed  = out_dspd_q;
	assign result.steam_speed   = out_sspd_q;

endmodule

`default_nettype wire

// ===== sv/dst_scan.sv =====
`default_nettype none

module dst_scan #(
	parameter int NUM_SECTORS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [dst_pkg::SENS_W-1:0]       top_sensors,
	input  logic [dst_pkg::SENS_W-1:0]       bottom_sensors,
	input  logic [dst_pkg::TIME_W-1:0]       time_ns,
	input  logic [dst_pkg::CNT_W-1:0]        clear_limit,
	output logic                             done,
	output dst_pkg::pair_t                   steam_times,
	output dst_pkg::pair_t                   diesel_times,
	output logic [$clog2(NUM_SECTORS)-1:0]   steam_sector,
	output logic [$clog2(NUM_SECTORS)-1:0]   diesel_sector
);
	import dst_pkg::*;

	localparam int SW = $clog2(NUM_SECTORS);

	logic                   busy_q;
	logic                   done_q;
	logic [SW-1:0]          k_q;
	logic [NUM_SECTORS-1:0] top_q;
	logic [NUM_SECTORS-1:0] bot_q;
	logic [TIME_W-1:0]      t_q;
	mode_t                  mode_q [NUM_SECTORS];
	logic [TIME_W-1:0]      etime_q [NUM_SECTORS];
	logic [CNT_W-1:0]       steam_cnt_q;
	logic [CNT_W-1:0]       diesel_cnt_q;
	logic [SW-1:0]          steam_sec_q;
	logic [SW-1:0]          diesel_sec_q;
	pair_t                  steam_pair_q;
	pair_t                  diesel_pair_q;

	logic              hi;
	logic              lo;
	mode_t             m;
	logic [TIME_W-1:0] et;
	mode_t             mode_nx;
	logic              et_wr;
	logic [CNT_W-1:0]  s_inc;
	logic [CNT_W-1:0]  d_inc;
	logic [CNT_W-1:0]  s_cnt_nx;
	logic [CNT_W-1:0]  d_cnt_nx;
	logic              s_conf;
	logic              d_conf;
	logic              last;

	always_comb begin
		hi       = top_q[0];
		lo       = bot_q[0];
		m        = mode_q[k_q];
		et       = etime_q[k_q];
		mode_nx  = m;
		et_wr    = 1'b0;
		s_inc    = steam_cnt_q + 1'b1;
		d_inc    = diesel_cnt_q + 1'b1;
		s_cnt_nx = steam_cnt_q;
		d_cnt_nx = diesel_cnt_q;
		s_conf   = 1'b0;
		d_conf   = 1'b0;
		last     = (k_q == SW'(NUM_SECTORS - 1));
		unique case (m)
			MODE_STEAM: begin
				if (!lo) begin
					s_cnt_nx = s_inc;
					if (s_inc == clear_limit) begin
						s_cnt_nx = '0;
						mode_nx  = MODE_IDLE;
						s_conf   = 1'b1;
					end
				end else begin
					s_cnt_nx = '0;
				end
			end
			MODE_CHECK: begin
				if (hi) begin
					mode_nx = MODE_STEAM;
					et_wr   = 1'b1;
				end else if (!lo) begin
					d_cnt_nx = d_inc;
					if (d_inc == clear_limit) begin
						d_cnt_nx = '0;
						mode_nx  = MODE_IDLE;
						d_conf   = 1'b1;
					end
				end else begin
					d_cnt_nx = '0;
				end
			end
			default: begin
				if (hi) begin
					mode_nx = MODE_STEAM;
					et_wr   = 1'b1;
				end else if (lo) begin
					mode_nx = MODE_CHECK;
					et_wr   = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			done_q        <= 1'b0;
			k_q           <= '0;
			steam_cnt_q   <= '0;
			diesel_cnt_q  <= '0;
			steam_sec_q   <= '0;
			diesel_sec_q  <= '0;
			steam_pair_q  <= '0;
			diesel_pair_q <= '0;
			for (int i = 0; i < NUM_SECTORS; i++) begin
				mode_q[i] <= MODE_IDLE;
			end
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				mode_q[k_q]  <= mode_nx;
				steam_cnt_q  <= s_cnt_nx;
				diesel_cnt_q <= d_cnt_nx;
				if (s_conf) begin
					steam_sec_q       <= k_q;
					steam_pair_q.prev <= steam_pair_q.cur;
					steam_pair_q.cur  <= et;
				end
				if (d_conf) begin
					diesel_sec_q       <= k_q;
					diesel_pair_q.prev <= diesel_pair_q.cur;
					diesel_pair_q.cur  <= et;
				end
				k_q <= k_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			top_q <= NUM_SECTORS'(top_sensors);
			bot_q <= NUM_SECTORS'(bottom_sensors);
			t_q   <= time_ns;
		end else if (busy_q) begin
			top_q <= top_q >> 1;
			bot_q <= bot_q >> 1;
			if (et_wr) begin
				etime_q[k_q] <= t_q;
			end
		end
	end

	assign done          = done_q;
	assign steam_times   = steam_pair_q;
	assign diesel_times  = diesel_pair_q;
	assign steam_sector  = steam_sec_q;
	assign diesel_sector = diesel_sec_q;

endmodule

`default_nettype wire

// ===== sv/dst_div.sv =====
`default_nettype none

module dst_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dst_pkg::div_req_t            req,
	output logic                         done,
	output logic [dst_pkg::SPEED_W-1:0]  quot
);
	import dst_pkg::*;

	localparam int STEP_W = $clog2(SPEED_W);

	typedef enum logic [4:0] {
		D_IDLE = 5'b00001,
		D_SUB  = 5'b00010,
		D_CHK  = 5'b00100,
		D_RUN  = 5'b01000,
		D_DONE = 5'b10000
	} dstate_t;

	dstate_t            state_q;
	logic [STEP_W-1:0]  step_q;
	logic               round_q;
	logic [TIME_W-1:0]  prev_q;
	logic [TIME_W-1:0]  cur_q;
	logic [TIME_W:0]    diff_q;
	logic               zero_q;
	logic [TIME_W-1:0]  rem_q;
	logic [SPEED_W-1:0] nlo_q;
	logic [SPEED_W-1:0] quot_q;

	logic [NUM_W-1:0]   num_sel;
	logic [TIME_W-1:0]  num_hi;
	logic [TIME_W:0]    shifted;
	logic [TIME_W+1:0]  trial;
	logic               fits;

	always_comb begin
		num_sel = round_q ? NUM_ROUND : NUM_STRAIGHT;
		num_hi  = TIME_W'(num_sel >> SPEED_W);
		shifted = {rem_q, nlo_q[SPEED_W-1]};
		trial   = {1'b0, shifted} - {2'b00, diff_q[TIME_W-1:0]};
		fits    = !trial[TIME_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_SUB;
					end
				end
				D_SUB: begin
					state_q <= D_CHK;
				end
				D_CHK: begin
					step_q <= '0;
					if (zero_q || diff_q[TIME_W] || (diff_q[TIME_W-1:0] <= num_hi)) begin
						state_q <= D_DONE;
					end else begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SPEED_W - 1)) begin
						state_q <= D_DONE;
					end
				end
				D_DONE: begin
					if (req.start) begin
						state_q <= D_SUB;
					end else begin
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE, D_DONE: begin
				if (req.start) begin
					round_q <= req.round;
					prev_q  <= req.times.prev;
					cur_q   <= req.times.cur;
				end
			end
			D_SUB: begin
				diff_q <= {1'b0, cur_q} - {1'b0, prev_q};
				zero_q <= (prev_q == '0) || (cur_q == '0);
			end
			D_CHK: begin
				if (zero_q || diff_q[TIME_W]) begin
					quot_q <= '0;
				end else if (diff_q[TIME_W-1:0] <= num_hi) begin
					quot_q <= SPEED_MAX;
				end else begin
					rem_q  <= num_hi;
					nlo_q  <= num_sel[SPEED_W-1:0];
					quot_q <= '0;
				end
			end
			D_RUN: begin
				rem_q  <= fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
				nlo_q  <= nlo_q << 1;
				quot_q <= {quot_q[SPEED_W-2:0], fits};
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == D_DONE);
	assign quot = quot_q;

endmodule

`default_nettype wire

// ===== sv/dst_checker.sv =====
`default_nettype none
`include "dual_sensor_train_tracker_defines.svh"

module dst_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [dst_pkg::SEC_W-1:0]    diesel_sector,
	input logic [dst_pkg::SEC_W-1:0]    steam_sector,
	input logic [dst_pkg::SPEED_W-1:0]  diesel_speed,
	input logic [dst_pkg::SPEED_W-1:0]  steam_speed
);
	import dst_pkg::*;

	logic [2*SEC_W+2*SPEED_W-1:0] out_word;
	logic                         in_take;

	assign out_word = {diesel_sector, steam_sector, diesel_speed, steam_speed};
	assign in_take  = in_valid && in_ready;

	`DST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_word), "Result word changed or dropped while stalled")
	`DST_ASSERT_NOW(a_out_drop, clk, arst_n, $fell(out_valid), $past(out_ready),
		"Result valid fell without a handshake")
	`DST_ASSERT_NEXT(a_busy, clk, arst_n, in_take, !in_ready,
		"Sample taken while the previous one is still being worked on")
	`DST_ASSERT_NOW(a_rise, clk, arst_n, $rose(out_valid), $past(!in_ready),
		"Result shown without a sample being worked on")

endmodule

bind dual_sensor_train_tracker dst_checker u_dst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample.valid),
	.in_ready     (sample.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.diesel_sector(result.diesel_sector),
	.steam_sector (result.steam_sector),
	.diesel_speed (result.diesel_speed),
	.steam_speed  (result.steam_speed)
);

`default_nettype wire
